FILE: design/msp_pkg.sv
// Package for the monotonic stack popper.
// Shared data width, default depth and the stack cell operation codes.
// No dependencies.
`default_nettype none
package msp_pkg;
  localparam int DATA_W = 32;
  localparam int DEF_STACK_DEPTH = 32;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP
  } stk_op_t;
endpackage
`default_nettype wire

FILE: design/msp_if.sv
// Valid/ready channel interfaces for the monotonic stack popper.
// Depends on msp_pkg for the data width.
`default_nettype none
interface msp_in_if;
  import msp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     is_last;
  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface msp_out_if;
  import msp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic                     overflow;
  logic                     run_end;
  modport source (output valid, output popped_value, output overflow,
                  output run_end, input ready);
  modport sink   (input valid, input popped_value, input overflow,
                  input run_end, output ready);
endinterface
`default_nettype wire

FILE: design/msp_cell.sv
// One stack cell: holds one entry, loads from the neighbor above on push
// and from the neighbor below on pop. Depends on msp_pkg.
`default_nettype none
module msp_cell (
  input  wire logic                 clk,
  input  wire msp_pkg::stk_op_t     op,
  input  wire logic [msp_pkg::DATA_W-1:0] up_data,
  input  wire logic [msp_pkg::DATA_W-1:0] down_data,
  output logic [msp_pkg::DATA_W-1:0]      data
);
  import msp_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      OP_PUSH: data <= up_data;
      OP_POP:  data <= down_data;
      default: data <= data;
    endcase
  end
endmodule
`default_nettype wire

FILE: design/monotonic_stack_popper_top.sv
// Monotonic increasing stack popper, top level.
// An accepted item is registered, then compared in S_POP; each popped entry is
// registered as a result, one result a cycle unless the output stalls. A new item
// is taken only in S_IDLE; pops are set by the compare on the top cell of the shift-register stack.
// Reset: rst (sync) empties the stack count and output; entries hold garbage.
// Depends on msp_pkg, msp_if, msp_cell.
`default_nettype none
module monotonic_stack_popper_top #(
  parameter int STACK_DEPTH = msp_pkg::DEF_STACK_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  msp_in_if.sink     in_ch,
  msp_out_if.source  out_ch
);
  import msp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_FLUSH} state_t;

  state_t                    state;
  logic [CW-1:0]             cnt;
  logic signed [DATA_W-1:0]  val;
  logic                      last;
  logic                      o_valid;
  logic [DATA_W-1:0]         o_value;
  logic                      o_ovf;
  logic                      o_end;

  stk_op_t                   op;
  logic [DATA_W-1:0]         cells [STACK_DEPTH];

  logic out_free;
  logic o_load;
  logic top_ge;
  logic next_ge;

  assign out_free = !o_valid || out_ch.ready;
  assign top_ge   = (cnt != '0) && ($signed(cells[0]) >= val);
  assign next_ge  = (cnt > CW'(1)) && ($signed(cells[1]) >= val);
  assign o_load   = out_free && ((state == S_FLUSH) ||
                    ((state == S_POP) && (top_ge || (cnt == CW'(STACK_DEPTH)))));

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = o_valid;
  assign out_ch.popped_value = o_value;
  assign out_ch.overflow     = o_ovf;
  assign out_ch.run_end      = o_end;

  always_comb begin
    op = OP_HOLD;
    if (out_free) begin
      case (state)
        S_POP: begin
          if (top_ge) begin
            op = OP_POP;
          end else if (cnt != CW'(STACK_DEPTH)) begin
            op = OP_PUSH;
          end
        end
        S_FLUSH: op = OP_POP;
        default: op = OP_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_d;
    logic [DATA_W-1:0] down_d;
    if (i == 0) begin : g_first
      assign up_d = val;
    end else begin : g_mid
      assign up_d = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_end
      assign down_d = cells[i];
    end else begin : g_inner
      assign down_d = cells[i+1];
    end
    msp_cell u_cell (
      .clk       (clk),
      .op        (op),
      .up_data   (up_d),
      .down_data (down_d),
      .data      (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            val   <= in_ch.value;
            last  <= in_ch.is_last;
            state <= S_POP;
          end
        end
        S_POP: begin
          if (out_free) begin
            if (top_ge) begin
              o_value <= cells[0];
              o_ovf   <= 1'b0;
              o_end   <= !next_ge && !last;
              cnt     <= cnt - CW'(1);
            end else begin
              if (cnt == CW'(STACK_DEPTH)) begin
                o_value <= val;
                o_ovf   <= 1'b1;
                o_end   <= !last;
              end else begin
                cnt <= cnt + CW'(1);
              end
              state <= last ? S_FLUSH : S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            o_value <= cells[0];
            o_ovf   <= 1'b0;
            o_end   <= (cnt == CW'(1));
            cnt     <= cnt - CW'(1);
            if (cnt == CW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/msp_checker.sv
// Port-level checker for the monotonic stack popper, bound to the top level.
// Depends on msp_pkg for the data width.
`default_nettype none
module msp_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [msp_pkg::DATA_W-1:0] popped_value,
  input wire logic                      overflow,
  input wire logic                      run_end
);
  import msp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(popped_value) && $stable(overflow)
                               && $stable(run_end))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");
endmodule

bind monotonic_stack_popper_top msp_checker u_msp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .popped_value (out_ch.popped_value),
  .overflow     (out_ch.overflow),
  .run_end      (out_ch.run_end)
);
`default_nettype wire
